>>> rtl/twcl_pkg.sv
// Package for the two-way cache lookup block.
// Holds field widths, configuration defaults, register indexes and the set metadata type.
// Depends on nothing; used by the top level, its checker and the testbench.
package twcl_pkg;

  localparam int SET_INDEX_BITS_DEF = 10;
  localparam int ADDR_W             = 32;
  localparam int TAG_W              = 32;
  localparam int OFFSET_W           = 16;
  localparam int SET_OUT_W          = 10;
  localparam int OFFSET_CFG_W       = 5;
  localparam int INDEX_CFG_W        = 4;
  localparam int CLAMP_W            = 5;
  localparam int SHIFT_W            = 6;
  localparam int CFG_ADDR_W         = 1;
  localparam int CFG_DATA_W         = 5;

  localparam logic [CLAMP_W-1:0]      MAX_OFFSET_BITS   = 5'd16;
  localparam logic [OFFSET_CFG_W-1:0] OFFSET_BITS_RESET = 5'd4;
  localparam logic [INDEX_CFG_W-1:0]  INDEX_BITS_RESET  = 4'd9;

  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_BITS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_INDEX_BITS  = 1'b1;

  // Per-set replacement state: next victim and one valid bit per way.
  typedef struct packed {
    logic       victim_right;
    logic [1:0] valid;
  } meta_t;

  localparam meta_t META_CLEAR = '{victim_right: 1'b0, valid: 2'b00};

endpackage

>>> rtl/two_way_cache_lookup.sv
// Top level of the two-way set-associative cache lookup with one LRU bit per set.
// Uses twcl_pkg for widths, configuration defaults and the set metadata type.
// Holds a tag memory and a metadata memory, each with a registered read port.

// Takes one byte address per word on the input channel and returns one word per address:
// hit, way, tag, set index and offset. An address is split by the offset_bits and index_bits
// registers, to be written only while the block is idle; the block itself does not enforce this.
// The block sustains one address per clock while out_stall is low and no clearing pass runs:
// an accepted address goes through the lookup stage registers and then the output register.
// The rate is set by the single read port of each memory, read at accept and written
// when the lookup retires; a write-forwarding register covers back-to-back same-set accesses.
// After reset the block runs a clearing pass over every metadata row; in_stall is high then.
module two_way_cache_lookup #(
  parameter int SET_INDEX_BITS = twcl_pkg::SET_INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [twcl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [twcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [twcl_pkg::ADDR_W-1:0]     in_address,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic                            out_way,
  output logic [twcl_pkg::TAG_W-1:0]      out_tag,
  output logic [twcl_pkg::SET_OUT_W-1:0]  out_set_index,
  output logic [twcl_pkg::OFFSET_W-1:0]   out_offset
);
  import twcl_pkg::*;

  localparam int NUM_SETS = 1 << SET_INDEX_BITS;
  localparam int SI       = SET_INDEX_BITS;

  // configuration registers
  logic [OFFSET_CFG_W-1:0] offset_bits_r;
  logic [INDEX_CFG_W-1:0]  index_bits_r;

  // memories
  logic [2*TAG_W-1:0] tag_mem [NUM_SETS];
  meta_t              meta_mem [NUM_SETS];
  logic [2*TAG_W-1:0] tag_rd_r;
  meta_t              meta_rd_r;

  // clearing pass
  logic          clr_active_r;
  logic [SI-1:0] clr_cnt_r;

  // address split
  logic [CLAMP_W-1:0]  ob;
  logic [CLAMP_W-1:0]  ib;
  logic [SHIFT_W-1:0]  shift;
  logic [SI-1:0]       set_mask;
  logic [SI-1:0]       in_set;
  logic [TAG_W-1:0]    in_tag;
  logic [OFFSET_W-1:0] in_off;
  logic                in_accept;

  // lookup stage
  logic                s1_valid_r;
  logic [SI-1:0]       s1_set_r;
  logic [TAG_W-1:0]    s1_tag_r;
  logic [OFFSET_W-1:0] s1_off_r;
  logic                s1_go;

  // last write, for forwarding
  logic               lw_valid_r;
  logic [SI-1:0]      lw_set_r;
  meta_t              lw_meta_r;
  logic [2*TAG_W-1:0] lw_tags_r;

  meta_t              meta_cur;
  logic [2*TAG_W-1:0] tags_cur;
  logic               hit0;
  logic               hit1;
  logic               lk_hit;
  logic               lk_way;
  meta_t              meta_nxt;
  logic [2*TAG_W-1:0] tags_nxt;

  // output register
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_way_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic [SET_OUT_W-1:0] out_set_r;
  logic [OFFSET_W-1:0]  out_off_r;

  // clamp widths and split the address
  always_comb begin
    ob = (offset_bits_r > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits_r;
    ib = ({1'b0, index_bits_r} > CLAMP_W'(SI)) ? CLAMP_W'(SI) : {1'b0, index_bits_r};
    shift    = {1'b0, ob} + {1'b0, ib};
    set_mask = ~({SI{1'b1}} << ib);
    in_set   = SI'(in_address >> ob) & set_mask;
    in_off   = in_address[OFFSET_W-1:0] & ~({OFFSET_W{1'b1}} << ob);
    in_tag   = (shift >= SHIFT_W'(TAG_W)) ? '0 : (in_address >> shift[SHIFT_W-2:0]);
  end

  assign s1_go     = !out_valid_r || !out_stall;
  assign in_stall  = clr_active_r || (s1_valid_r && !s1_go);
  assign in_accept = in_valid && !in_stall;

  // pick forwarded row when the previous write hit the same set
  always_comb begin
    if (lw_valid_r && (lw_set_r == s1_set_r)) begin
      meta_cur = lw_meta_r;
      tags_cur = lw_tags_r;
    end else begin
      meta_cur = meta_rd_r;
      tags_cur = tag_rd_r;
    end
    hit0     = meta_cur.valid[0] && (tags_cur[TAG_W-1:0] == s1_tag_r);
    hit1     = meta_cur.valid[1] && (tags_cur[2*TAG_W-1:TAG_W] == s1_tag_r);
    meta_nxt = meta_cur;
    tags_nxt = tags_cur;
    if (hit0) begin
      lk_hit = 1'b1;
      lk_way = 1'b0;
      meta_nxt.victim_right = 1'b1;
    end else if (hit1) begin
      lk_hit = 1'b1;
      lk_way = 1'b1;
      meta_nxt.victim_right = 1'b0;
    end else begin
      lk_hit = 1'b0;
      lk_way = meta_cur.victim_right;
      // fill the victim way
      if (lk_way) begin
        tags_nxt[2*TAG_W-1:TAG_W] = s1_tag_r;
        meta_nxt.valid[1]         = 1'b1;
      end else begin
        tags_nxt[TAG_W-1:0] = s1_tag_r;
        meta_nxt.valid[0]   = 1'b1;
      end
      meta_nxt.victim_right = ~lk_way;
    end
  end

  // tag memory: read at accept, write back when the lookup retires
  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go) begin
      tag_mem[s1_set_r] <= tags_nxt;
    end
    if (in_accept) begin
      tag_rd_r <= tag_mem[in_set];
    end
  end

  // metadata memory: cleared row by row after reset
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      meta_mem[clr_cnt_r] <= META_CLEAR;
    end else if (s1_valid_r && s1_go) begin
      meta_mem[s1_set_r] <= meta_nxt;
    end
    if (in_accept) begin
      meta_rd_r <= meta_mem[in_set];
    end
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFFSET_BITS_RESET;
      index_bits_r  <= INDEX_BITS_RESET;
      clr_active_r  <= 1'b1;
      clr_cnt_r     <= '0;
      s1_valid_r    <= 1'b0;
      lw_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_OFFSET_BITS: offset_bits_r <= cfg_wdata[OFFSET_CFG_W-1:0];
          REG_INDEX_BITS:  index_bits_r  <= cfg_wdata[INDEX_CFG_W-1:0];
          default: ;
        endcase
      end
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_valid_r && s1_go) begin
        lw_valid_r  <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_set_r <= in_set;
      s1_tag_r <= in_tag;
      s1_off_r <= in_off;
    end
    if (s1_valid_r && s1_go) begin
      lw_set_r  <= s1_set_r;
      lw_meta_r <= meta_nxt;
      lw_tags_r <= tags_nxt;
      out_hit_r <= lk_hit;
      out_way_r <= lk_way;
      out_tag_r <= s1_tag_r;
      out_set_r <= SET_OUT_W'(s1_set_r);
      out_off_r <= s1_off_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_way       = out_way_r;
  assign out_tag       = out_tag_r;
  assign out_set_index = out_set_r;
  assign out_offset    = out_off_r;

endmodule

>>> rtl/twcl_checker.sv
// Port-level checker for the two-way cache lookup, attached by a bind at the end of the file.
// Uses twcl_pkg for port widths; sees only the top level's ports.
module twcl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_we,
  input logic [twcl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [twcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [twcl_pkg::ADDR_W-1:0]     in_address,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_hit,
  input logic                            out_way,
  input logic [twcl_pkg::TAG_W-1:0]      out_tag,
  input logic [twcl_pkg::SET_OUT_W-1:0]  out_set_index,
  input logic [twcl_pkg::OFFSET_W-1:0]   out_offset
);
  import twcl_pkg::*;

  // reset starts the clearing pass, so no address is taken right after it
  a_reset_stalls: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("in_stall low right after reset");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a new result word is seen only after an address was taken and held in the lookup stage
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without an address two cycles before");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_way)
      && $stable(out_tag) && $stable(out_set_index) && $stable(out_offset))
    else $error("stalled result word changed");

endmodule

bind two_way_cache_lookup twcl_checker u_twcl_checker (.*);

>>> test/two_way_cache_lookup_test.sv
// Self-checking testbench for two_way_cache_lookup: a scoreboard class mirrors the
// per-set tags, valid bits and LRU bit and checks every result word in order.
// Depends on twcl_pkg and the two_way_cache_lookup top level only.
import twcl_pkg::*;

typedef struct packed {
  logic                 hit;
  logic                 way;
  logic [TAG_W-1:0]     tag;
  logic [SET_OUT_W-1:0] set_index;
  logic [OFFSET_W-1:0]  offset;
} lookup_t;

class lookup_scoreboard;
  logic [OFFSET_CFG_W-1:0] offset_bits_q;
  logic [INDEX_CFG_W-1:0]  index_bits_q;
  logic [TAG_W-1:0]        left_tags  [1 << SET_INDEX_BITS_DEF];
  logic [TAG_W-1:0]        right_tags [1 << SET_INDEX_BITS_DEF];
  logic [1:0]              way_valid  [1 << SET_INDEX_BITS_DEF];
  logic                    victim_right [1 << SET_INDEX_BITS_DEF];
  lookup_t                 lookups_due [$];
  int                      errors;
  int                      hits;
  int                      misses;

  function new();
    offset_bits_q = OFFSET_BITS_RESET;
    index_bits_q  = INDEX_BITS_RESET;
    foreach (way_valid[i]) begin
      left_tags[i]    = '0;
      right_tags[i]   = '0;
      way_valid[i]    = 2'b00;
      victim_right[i] = 1'b0;
    end
    errors = 0;
    hits   = 0;
    misses = 0;
  endfunction

  function int eff_offset();
    return (offset_bits_q > MAX_OFFSET_BITS) ? int'(MAX_OFFSET_BITS) : int'(offset_bits_q);
  endfunction

  function int eff_index();
    return (index_bits_q > SET_INDEX_BITS_DEF) ? SET_INDEX_BITS_DEF : int'(index_bits_q);
  endfunction

  function int pending();
    return lookups_due.size();
  endfunction

  function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_OFFSET_BITS: offset_bits_q = value[OFFSET_CFG_W-1:0];
      REG_INDEX_BITS:  index_bits_q  = value[INDEX_CFG_W-1:0];
      default: ;
    endcase
  endfunction

  // Look up one address and update the set as the block does when the lookup retires.
  function void note_address(logic [ADDR_W-1:0] addr);
    int          ob;
    int          ib;
    int unsigned s;
    lookup_t     r;
    ob = eff_offset();
    ib = eff_index();
    s = (addr >> ob) & ((32'h1 << ib) - 1);
    r.offset    = OFFSET_W'(addr & ((32'h1 << ob) - 1));
    r.set_index = SET_OUT_W'(s);
    r.tag       = addr >> (ob + ib);
    if (way_valid[s][0] && left_tags[s] == r.tag) begin
      r.hit = 1'b1;
      r.way = 1'b0;
      victim_right[s] = 1'b1;
    end else if (way_valid[s][1] && right_tags[s] == r.tag) begin
      r.hit = 1'b1;
      r.way = 1'b1;
      victim_right[s] = 1'b0;
    end else begin
      // Fill the victim way and point the LRU bit at the other one.
      r.hit = 1'b0;
      r.way = victim_right[s];
      if (r.way) right_tags[s] = r.tag;
      else left_tags[s] = r.tag;
      way_valid[s][r.way] = 1'b1;
      victim_right[s] = ~r.way;
    end
    lookups_due.push_back(r);
  endfunction

  function void report(string field, logic [31:0] want_v, logic [31:0] got_v);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
    errors++;
  endfunction

  function void check_result(lookup_t got);
    lookup_t want;
    if (lookups_due.size() == 0) begin
      $display("%0t: result word with nothing outstanding, tag 0x%0h set %0d",
               $time, got.tag, got.set_index);
      errors++;
      return;
    end
    want = lookups_due.pop_front();
    if (got.hit !== want.hit) report("hit", 32'(want.hit), 32'(got.hit));
    if (got.way !== want.way) report("way", 32'(want.way), 32'(got.way));
    if (got.tag !== want.tag) report("tag", want.tag, got.tag);
    if (got.set_index !== want.set_index) begin
      report("set_index", 32'(want.set_index), 32'(got.set_index));
    end
    if (got.offset !== want.offset) report("offset", 32'(want.offset), 32'(got.offset));
    if (got.hit) hits++;
    else misses++;
  endfunction
endclass

module two_way_cache_lookup_test;
  localparam int RANDOM_PER_SPLIT = 170;
  localparam int NUM_SPLITS       = 9;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_ADDR_W-1:0]    cfg_addr;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [ADDR_W-1:0]        in_address;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_hit;
  logic                     out_way;
  logic [TAG_W-1:0]         out_tag;
  logic [SET_OUT_W-1:0]     out_set_index;
  logic [OFFSET_W-1:0]      out_offset;

  lookup_scoreboard sb;
  bit               calm_in;
  bit               calm_out;

  // Extremes and out-of-range widths (clamped by the block), a middle split, then random splits.
  logic [CFG_DATA_W-1:0] offset_plan [NUM_SPLITS] = '{0, 16, 31, 0, 16, 17, 5, 0, 0};
  logic [CFG_DATA_W-1:0] index_plan  [NUM_SPLITS] = '{0, 10, 31, 10, 0, 11, 3, 0, 0};

  logic [ADDR_W-1:0] directed_addrs [21] = '{
    32'h0000_0000, 32'h0000_000F, 32'h0000_2000, 32'h0000_0000, 32'h0000_4000,
    32'h0000_2000, 32'h0000_4005, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_E00F,
    32'h0000_1FF0, 32'hFFFF_FFF0, 32'h0000_1FFF, 32'h8000_0000, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
    32'hAAAA_AAAA
  };

  two_way_cache_lookup u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_address    (in_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_way       (out_way),
    .out_tag       (out_tag),
    .out_set_index (out_set_index),
    .out_offset    (out_offset)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic send_address(input logic [ADDR_W-1:0] addr);
    int gap;
    gap = draw_gap(calm_in);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_address = addr;
    do @(posedge clk); while (in_stall);
    sb.note_address(addr);
  endtask

  // Hold valid low until every outstanding word has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_split(input logic [CFG_DATA_W-1:0] ob, input logic [CFG_DATA_W-1:0] ib);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = REG_OFFSET_BITS;
    cfg_wdata = ob;
    @(posedge clk);
    sb.write_reg(REG_OFFSET_BITS, ob);
    @(negedge clk);
    cfg_addr  = REG_INDEX_BITS;
    cfg_wdata = ib;
    @(posedge clk);
    sb.write_reg(REG_INDEX_BITS, ib);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly reuse a few tags and sets so lines hit, get evicted and refill.
  task automatic run_random(input int count);
    logic [ADDR_W-1:0] tag_pool [4];
    int unsigned       set_pool [3];
    int                ob;
    int                ib;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] set_v;
    ob = sb.eff_offset();
    ib = sb.eff_index();
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    foreach (set_pool[i]) set_pool[i] = $urandom_range(0, (1 << ib) - 1);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm_in = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        addr = $urandom;
      end else begin
        set_v = $urandom_range(0, 1) ? set_pool[$urandom_range(0, 2)] : $urandom;
        addr = (tag_pool[$urandom_range(0, 3)] << (ob + ib))
             | ((set_v & ((32'h1 << ib) - 1)) << ob)
             | ($urandom & ((32'h1 << ob) - 1));
      end
      send_address(addr);
    end
  endtask

  // Result side: stall a random number of cycles ahead of each word.
  initial begin
    int gap;
    int taken;
    taken = 0;
    forever begin
      if (taken % 40 == 0) calm_out = ($urandom_range(0, 3) == 0);
      gap = draw_gap(calm_out);
      repeat (gap) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{hit: out_hit, way: out_way, tag: out_tag,
                        set_index: out_set_index, offset: out_offset});
    end
  end

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_OFFSET_BITS;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_address = '0;
    out_stall  = 1'b0;
    calm_in    = 1'b0;
    calm_out   = 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset split first: fills, hits on both ways, LRU eviction, corner addresses.
    foreach (directed_addrs[i]) send_address(directed_addrs[i]);

    for (int p = 0; p < NUM_SPLITS; p++) begin
      drain();
      if (p >= 7) begin
        offset_plan[p] = CFG_DATA_W'($urandom_range(0, 31));
        index_plan[p]  = CFG_DATA_W'($urandom_range(0, 31));
      end
      write_split(offset_plan[p], index_plan[p]);
      run_random(RANDOM_PER_SPLIT);
    end
    drain();

    $display("Checked %0d lookups (%0d hits, %0d misses) over %0d address splits,",
             sb.hits + sb.misses, sb.hits, sb.misses, NUM_SPLITS + 1);
    $display("including clamped offset and index widths and back-to-back same-set words.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
